// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
// every check samples on clk_i and is off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define BTBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BTBA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/btba_pkg.sv
`default_nettype none
package btba_pkg;

  // store geometry
  localparam int unsigned STORE_BYTES = 1024;
  localparam int unsigned BLOCK_ALIGN = 16;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned BANK_AW     = ADDR_W - 1;
  localparam int unsigned BANK_DEPTH  = STORE_BYTES / 2;
  localparam int unsigned ALIGN_W     = $clog2(BLOCK_ALIGN);

  // tag layout and arithmetic widths
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned AT_W     = 16;
  localparam int unsigned TAG_PAIR = 2 + 2;
  localparam logic [TAG_W-1:0] TAG_USED = 16'h8000;
  localparam logic [TAG_W-1:0] FMT_SIZE = TAG_W'(STORE_BYTES - BLOCK_ALIGN - TAG_PAIR);

  // item field widths
  localparam int unsigned FIELD_W = 10;
  localparam int unsigned REQ_W   = 10;
  localparam int unsigned RSZ_W   = REQ_W + 1;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  // command queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_FORMAT  = 2'd2,
    OP_INSPECT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_FORMAT,
    CMD_INSPECT,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e               kind;
    logic [RSZ_W-1:0]   size;
    logic [FIELD_W-1:0] addr;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_AL_W0,
    ST_AL_W1,
    ST_AL_W2,
    ST_AL_W3,
    ST_FR_RD0,
    ST_FR_EV0,
    ST_FR_EVP,
    ST_FR_NX,
    ST_FR_EVN,
    ST_FR_W0,
    ST_FR_W1,
    ST_FMT_W0,
    ST_FMT_W1,
    ST_DONE
  } st_e;

endpackage
`default_nettype wire

// File: rtl/btba_if.sv
`default_nettype none
// request channel
interface btba_req_if import btba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [REQ_W-1:0]   request_size;
  logic [FIELD_W-1:0] payload_address;

  modport source(output valid, output operation, output request_size,
                 output payload_address, input ready);
  modport sink(input valid, input operation, input request_size,
               input payload_address, output ready);
endinterface

// result channel
interface btba_rsp_if import btba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] granted_address;
  logic [FIELD_W-1:0] free_blocks;
  logic [FIELD_W-1:0] free_bytes_total;
  logic [FIELD_W-1:0] largest_free_block;

  modport source(output valid, output granted_address, output free_blocks,
                 output free_bytes_total, output largest_free_block, input ready);
  modport sink(input valid, input granted_address, input free_blocks,
               input free_bytes_total, input largest_free_block, output ready);
endinterface
`default_nettype wire

// File: rtl/btba_front.sv
`default_nettype none
module btba_front import btba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  btba_req_if.sink    req_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_ready_i
);

  logic             stg_valid_q, stg_valid_d;
  cmd_t             stg_q, stg_d;
  cmd_t             cls;
  logic [RSZ_W-1:0] req_min;
  logic [RSZ_W-1:0] req_sum;
  logic [AT_W-1:0]  addr_ext;
  logic             take;

  // classify the incoming item
  always_comb begin
    req_min  = (req_i.request_size == '0) ? RSZ_W'(1) : RSZ_W'(req_i.request_size);
    req_sum  = req_min + RSZ_W'(BLOCK_ALIGN - 1);
    addr_ext = AT_W'(req_i.payload_address);
    cls.size = req_sum & ~RSZ_W'(BLOCK_ALIGN - 1);
    cls.addr = req_i.payload_address;
    case (op_e'(req_i.operation))
      OP_ALLOC:   cls.kind = CMD_ALLOC;
      OP_FREE: begin
        if (addr_ext == '0 || addr_ext < AT_W'(BLOCK_ALIGN + 2) ||
            addr_ext > AT_W'(STORE_BYTES - 2)) begin
          cls.kind = CMD_NOP;
        end else begin
          cls.kind = CMD_FREE;
        end
      end
      OP_FORMAT:  cls.kind = CMD_FORMAT;
      OP_INSPECT: cls.kind = CMD_INSPECT;
      default:    cls.kind = CMD_NOP;
    endcase
  end

  // staging register toward the queue
  assign req_i.ready = !stg_valid_q || cmd_ready_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    stg_valid_d = stg_valid_q;
    stg_d       = stg_q;
    if (take) begin
      stg_valid_d = 1'b1;
      stg_d       = cls;
    end else if (cmd_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign cmd_valid_o = stg_valid_q;
  assign cmd_o       = stg_q;

endmodule
`default_nettype wire

// File: rtl/btba_fifo.sv
`default_nettype none
`include "assert_macros.svh"
module btba_fifo import btba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_data_o,
  input  logic pop_ready_i
);

  cmd_t            ent_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != Q_CW'(Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BTBA_ASSERT(a_cnt_bound, cnt_q <= Q_CW'(Q_DEPTH), "queue fill count overflow")
  `BTBA_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "lost push")
  `BTBA_ASSERT_IMPL(a_full_stalls, cnt_q == Q_CW'(Q_DEPTH), !push_ready_o, "ready while full")

endmodule
`default_nettype wire

// File: rtl/btba_back.sv
`default_nettype none
`include "assert_macros.svh"
module btba_back import btba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  btba_rsp_if.source rsp_o
);

  // tag memory split into even and odd byte banks
  logic [7:0] even_mem [BANK_DEPTH];
  logic [7:0] odd_mem  [BANK_DEPTH];
  logic [7:0] even_rd_q, odd_rd_q;
  logic       rd_par_q;

  st_e                st_q, st_d;
  cmd_e               kind_q, kind_d;
  logic [RSZ_W-1:0]   size_q, size_d;
  logic [AT_W-1:0]    at_q, at_d;
  logic [AT_W-1:0]    bsize_q, bsize_d;
  logic [AT_W-1:0]    count_q, count_d;
  logic [AT_W-1:0]    total_q, total_d;
  logic [SIZE_W-1:0]  largest_q, largest_d;
  logic [FIELD_W-1:0] grant_q, grant_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic [FIELD_W-1:0] rsp_grant_q, rsp_count_q, rsp_total_q, rsp_largest_q;

  logic [TAG_W-1:0]  rd_tag;
  logic [AT_W-1:0]   tag_size;
  logic [AT_W-1:0]   size_ext;
  logic [AT_W-1:0]   at_next;
  logic [AT_W+1:0]   nxt_sum;
  logic              at_in_range, fit, has_prev, nxt_in_range, split;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [TAG_W-1:0]  wr_data;
  logic              wr_en, cmd_pop, rsp_load;

  // tag view of the registered bank data
  assign rd_tag   = rd_par_q ? {even_rd_q, odd_rd_q} : {odd_rd_q, even_rd_q};
  assign tag_size = AT_W'(rd_tag[SIZE_W-1:0]);
  assign size_ext = AT_W'(size_q);
  assign at_next  = at_q + AT_W'(TAG_PAIR) + tag_size;
  assign nxt_sum  = (AT_W+2)'(at_q) + (AT_W+2)'(TAG_PAIR) + (AT_W+2)'(bsize_q);

  assign at_in_range  = at_q <= AT_W'(STORE_BYTES - TAG_PAIR);
  assign fit          = !rd_tag[TAG_W-1] &&
                        (tag_size == size_ext || tag_size >= size_ext + AT_W'(TAG_PAIR));
  assign has_prev     = at_q >= AT_W'(BLOCK_ALIGN + 4);
  assign nxt_in_range = nxt_sum <= (AT_W+2)'(STORE_BYTES - TAG_PAIR);
  assign split        = bsize_q != size_ext;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_ALLOC, CMD_INSPECT: st_d = ST_WALK_RD;
            CMD_FREE:               st_d = ST_FR_RD0;
            CMD_FORMAT:             st_d = ST_FMT_W0;
            default:                st_d = ST_DONE;
          endcase
        end
      end
      ST_WALK_RD: st_d = at_in_range ? ST_WALK_EV : ST_DONE;
      ST_WALK_EV: st_d = (kind_q == CMD_ALLOC && fit) ? ST_AL_W0 : ST_WALK_RD;
      ST_AL_W0:   st_d = ST_AL_W1;
      ST_AL_W1:   st_d = split ? ST_AL_W2 : ST_DONE;
      ST_AL_W2:   st_d = ST_AL_W3;
      ST_AL_W3:   st_d = ST_DONE;
      ST_FR_RD0:  st_d = ST_FR_EV0;
      ST_FR_EV0: begin
        if (!rd_tag[TAG_W-1]) begin
          st_d = ST_DONE;
        end else begin
          st_d = has_prev ? ST_FR_EVP : ST_FR_NX;
        end
      end
      ST_FR_EVP:  st_d = ST_FR_NX;
      ST_FR_NX:   st_d = nxt_in_range ? ST_FR_EVN : ST_FR_W0;
      ST_FR_EVN:  st_d = ST_FR_W0;
      ST_FR_W0:   st_d = ST_FR_W1;
      ST_FR_W1:   st_d = ST_DONE;
      ST_FMT_W0:  st_d = ST_FMT_W1;
      ST_FMT_W1:  st_d = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          st_d = ST_IDLE;
        end
      end
      default:    st_d = ST_IDLE;
    endcase
  end

  // state outputs: memory ports and handshakes
  always_comb begin
    rd_addr  = at_q[ADDR_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = at_q[ADDR_W-1:0];
    wr_data  = bsize_q;
    rsp_load = 1'b0;
    case (st_q)
      ST_FR_EV0: rd_addr = ADDR_W'(at_q - AT_W'(2));
      ST_FR_NX:  rd_addr = nxt_sum[ADDR_W-1:0];
      ST_AL_W0: begin
        wr_en   = 1'b1;
        wr_data = TAG_USED | size_ext;
      end
      ST_AL_W1: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(at_q + AT_W'(2) + size_ext);
        wr_data = TAG_USED | size_ext;
      end
      ST_AL_W2: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(at_q + AT_W'(TAG_PAIR) + size_ext);
        wr_data = bsize_q - AT_W'(TAG_PAIR) - size_ext;
      end
      ST_AL_W3: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(at_q + AT_W'(2) + bsize_q);
        wr_data = bsize_q - AT_W'(TAG_PAIR) - size_ext;
      end
      ST_FR_W0:  wr_en = 1'b1;
      ST_FR_W1: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(at_q + AT_W'(2) + bsize_q);
      end
      ST_FMT_W0: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(BLOCK_ALIGN);
        wr_data = FMT_SIZE;
      end
      ST_FMT_W1: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(STORE_BYTES - 2);
        wr_data = FMT_SIZE;
      end
      ST_DONE:   rsp_load = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign cmd_ready_o = st_q == ST_IDLE;
  assign cmd_pop     = cmd_ready_o && cmd_valid_i;

  // working registers
  always_comb begin
    kind_d    = kind_q;
    size_d    = size_q;
    at_d      = at_q;
    bsize_d   = bsize_q;
    count_d   = count_q;
    total_d   = total_q;
    largest_d = largest_q;
    grant_d   = grant_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_pop) begin
          kind_d    = cmd_i.kind;
          size_d    = cmd_i.size;
          at_d      = (cmd_i.kind == CMD_FREE) ? AT_W'(cmd_i.addr) - AT_W'(2)
                                               : AT_W'(BLOCK_ALIGN);
          bsize_d   = '0;
          count_d   = '0;
          total_d   = '0;
          largest_d = '0;
          grant_d   = '0;
        end
      end
      ST_WALK_EV: begin
        if (kind_q == CMD_ALLOC && fit) begin
          bsize_d = tag_size;
          grant_d = FIELD_W'(at_q + AT_W'(2));
        end else begin
          at_d = at_next;
          if (kind_q == CMD_INSPECT && !rd_tag[TAG_W-1]) begin
            count_d = count_q + 1'b1;
            total_d = total_q + tag_size;
            if (rd_tag[SIZE_W-1:0] > largest_q) begin
              largest_d = rd_tag[SIZE_W-1:0];
            end
          end
        end
      end
      ST_FR_EV0: bsize_d = tag_size;
      ST_FR_EVP: begin
        if (!rd_tag[TAG_W-1]) begin
          at_d    = at_q - AT_W'(TAG_PAIR) - tag_size;
          bsize_d = bsize_q + AT_W'(TAG_PAIR) + tag_size;
        end
      end
      ST_FR_EVN: begin
        if (!rd_tag[TAG_W-1]) begin
          bsize_d = bsize_q + AT_W'(TAG_PAIR) + tag_size;
        end
      end
      default: ;
    endcase
  end

  // result register valid
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    size_q    <= size_d;
    at_q      <= at_d;
    bsize_q   <= bsize_d;
    count_q   <= count_d;
    total_q   <= total_d;
    largest_q <= largest_d;
    grant_q   <= grant_d;
  end

  // result payload, saturated for inspect
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_grant_q   <= '0;
      rsp_count_q   <= '0;
      rsp_total_q   <= '0;
      rsp_largest_q <= '0;
      case (kind_q)
        CMD_ALLOC: rsp_grant_q <= grant_q;
        CMD_INSPECT: begin
          rsp_count_q   <= (count_q > AT_W'(FIELD_MAX)) ? FIELD_MAX
                                                        : count_q[FIELD_W-1:0];
          rsp_total_q   <= (total_q > AT_W'(FIELD_MAX)) ? FIELD_MAX
                                                        : total_q[FIELD_W-1:0];
          rsp_largest_q <= (largest_q > SIZE_W'(FIELD_MAX)) ? FIELD_MAX
                                                            : largest_q[FIELD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // byte bank write, lane swap on odd addresses
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (wr_addr[0]) begin
        odd_mem[wr_addr[ADDR_W-1:1]]         <= wr_data[7:0];
        even_mem[wr_addr[ADDR_W-1:1] + 1'b1] <= wr_data[15:8];
      end else begin
        even_mem[wr_addr[ADDR_W-1:1]] <= wr_data[7:0];
        odd_mem[wr_addr[ADDR_W-1:1]]  <= wr_data[15:8];
      end
    end
  end

  // byte bank read, data registered
  always_ff @(posedge clk_i) begin
    even_rd_q <= even_mem[rd_addr[0] ? rd_addr[ADDR_W-1:1] + 1'b1 : rd_addr[ADDR_W-1:1]];
    odd_rd_q  <= odd_mem[rd_addr[ADDR_W-1:1]];
    rd_par_q  <= rd_addr[0];
  end

  assign rsp_o.valid              = rsp_valid_q;
  assign rsp_o.granted_address    = rsp_grant_q;
  assign rsp_o.free_blocks        = rsp_count_q;
  assign rsp_o.free_bytes_total   = rsp_total_q;
  assign rsp_o.largest_free_block = rsp_largest_q;

  `BTBA_ASSERT_NEXT(a_pop_leaves_idle, cmd_pop, st_q != ST_IDLE, "command taken but idle")
  `BTBA_ASSERT_NEXT(a_walk_advances, (st_q == ST_WALK_EV) && (st_d == ST_WALK_RD),
                    at_q > $past(at_q), "block walk did not advance")
  `BTBA_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_q), $past(st_q) == ST_DONE,
                    "result raised outside done")

endmodule
`default_nettype wire

// File: rtl/boundary_tag_block_allocator_top.sv
// path: front staging register and command queue, then the op ending in its done state:
// format writes two tags; free reads its tag and, if the block is used, its neighbours in
// range, then writes two tags; inspect and alloc walk the blocks, an alloc hit writing two
// tags, four when it splits; the result register loads in the done state once rsp is free
// the back end takes a new item only when idle; the tag memory, read once per block, sets
// the rate; reset clears control and queue state only; tag memory holds garbage until format
`default_nettype none
module boundary_tag_block_allocator_top import btba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  btba_req_if.sink   req_i,
  btba_rsp_if.source rsp_o
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // accept and classify
  btba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (fr_ready)
  );

  // command queue
  btba_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_data_i  (fr_cmd),
    .push_ready_o (fr_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_cmd),
    .pop_ready_i  (q_ready)
  );

  // tag memory sequencer
  btba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_ready_o (q_ready),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire
